>>> rtl/rgbl_pkg.sv
// Package for the RGB LED animation sequencer: codes, config and step types,
// and the gamma ROM contents built at elaboration. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rgbl_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned NUM_CH     = 3;

	// Config register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANIM_SELECT = 3'd0,
		REG_STEP_DELAY  = 3'd1,
		REG_HOLD_DELAY  = 3'd2,
		REG_MAX_LEVEL   = 3'd3,
		REG_GAMMA_EN    = 3'd4
	} reg_idx_t;

	// Animation select codes
	localparam logic [2:0] SEL_OFF      = 3'd0;
	localparam logic [2:0] SEL_WHEEL    = 3'd1;
	localparam logic [2:0] SEL_FADE     = 3'd2;
	localparam logic [2:0] SEL_BREATHE7 = 3'd3;
	localparam logic [2:0] SEL_BREATHE3 = 3'd4;

	localparam logic [7:0] BREATHE_TOP = 8'd255;
	localparam logic [63:0] GAMMA_OFFSET = 64'd12238302;

	typedef struct packed {
		logic [2:0]  anim_select;
		logic [15:0] step_delay_ms;
		logic [15:0] hold_delay_ms;
		logic [7:0]  max_level;
		logic        gamma_enable;
	} cfg_t;

	// One step's effect on the duty channels (channel 0 red, 1 green, 2 blue)
	typedef struct packed {
		logic                     emit;
		logic                     clr;
		logic                     gamma_en;
		logic [NUM_CH-1:0]        wr;
		logic [NUM_CH-1:0][7:0]   lvl;
	} step_t;

	typedef logic [7:0] gamma_rom_t [256];

	// log2 in unsigned Q20, fraction by repeated squaring of a Q30 mantissa
	function automatic logic [63:0] log2_q20(input logic [7:0] x);
		logic [63:0] m;
		logic [63:0] r;
		int unsigned n;
		n = 0;
		for (int i = 1; i < 8; i++)
			if ((x >> i) != 8'd0) n = i;
		m = {56'd0, x} << (30 - n);
		r = 64'(n);
		for (int i = 0; i < 20; i++) begin
			m = (m * m) >> 30;
			r = r << 1;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				r = r | 64'd1;
			end
		end
		return r;
	endfunction

	// floor(0.0003066 * v^2.46) evaluated in the log domain
	function automatic gamma_rom_t build_gamma();
		gamma_rom_t  g;
		logic [63:0] lk [256];
		logic [63:0] lv;
		int unsigned cnt;
		lk[0] = '0;
		for (int k = 1; k < 256; k++)
			lk[k] = 64'd100 * log2_q20(8'(k)) + 64'd100 * GAMMA_OFFSET;
		g[0] = 8'd0;
		for (int v = 1; v < 256; v++) begin
			lv = 64'd246 * log2_q20(8'(v));
			cnt = 0;
			for (int k = 1; k < 256; k++)
				if (lk[k] <= lv) cnt++;
			g[v] = (cnt > 255) ? 8'd255 : 8'(cnt);
		end
		return g;
	endfunction

	localparam gamma_rom_t GAMMA_ROM = build_gamma();

endpackage
`default_nettype wire

>>> rtl/rgbl_ifs.sv
// Valid/ready channel interfaces for the sequencer: input items, results and
// config writes. Depends on rgbl_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface rgbl_item_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [31:0] now_ms;
	modport source (output valid, output cmd, output now_ms, input ready);
	modport sink   (input valid, input cmd, input now_ms, output ready);
endinterface

interface rgbl_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_duty;
	logic [7:0] green_duty;
	logic [7:0] blue_duty;
	modport source (output valid, output red_duty, output green_duty, output blue_duty,
		input ready);
	modport sink   (input valid, input red_duty, input green_duty, input blue_duty,
		output ready);
endinterface

interface rgbl_cfg_if
	import rgbl_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/rgbl_anim.sv
// Animation state and step logic: timer check, wheel/crossfade/breathe
// sequencing, produces per-channel raw levels. Depends on rgbl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rgbl_anim
	import rgbl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        accept,
	input  wire logic        cmd,
	input  wire logic [31:0] now_ms,
	output step_t            step
);

	logic [8:0]  ramp_q, ramp_d;
	logic [2:0]  phase_q, phase_d;
	logic [15:0] delay_q, delay_d;
	logic [31:0] last_q, last_d;
	logic        fade_started_q, fade_started_d;
	logic        falling_q, falling_d;
	logic        pick_q, pick_d;
	logic [2:0]  colour_q, colour_d;

	logic [31:0]        since;
	logic               elapsed;
	logic               running;
	logic [9:0]         inc;
	logic               wrap;
	logic [7:0]         up_lvl;
	logic [7:0]         dn_lvl;
	logic               dn_ok;
	logic [7:0]         mx;
	logic [3:0]         c_next;
	logic [3:0]         lim;
	logic [2:0]         c;
	logic signed [10:0] ns;

	assign since   = now_ms - last_q;
	assign elapsed = since >= {16'd0, delay_q};
	assign mx      = cfg.max_level;
	assign inc     = {1'b0, ramp_q} + 10'd1;
	assign wrap    = inc > {2'b00, mx};
	assign up_lvl  = ramp_q[8] ? 8'hFF : ramp_q[7:0];
	assign dn_ok   = ramp_q <= {1'b0, mx};
	assign dn_lvl  = mx - ramp_q[7:0];

	always_comb begin
		ramp_d         = ramp_q;
		phase_d        = phase_q;
		delay_d        = delay_q;
		last_d         = last_q;
		fade_started_d = fade_started_q;
		falling_d      = falling_q;
		pick_d         = pick_q;
		colour_d       = colour_q;
		step           = '0;
		step.gamma_en  = cfg.gamma_enable;
		running        = 1'b0;
		lim            = 4'd3;
		c_next         = '0;
		c              = colour_q;
		ns             = '0;
		case (cfg.anim_select)
			SEL_WHEEL, SEL_FADE, SEL_BREATHE7, SEL_BREATHE3: running = 1'b1;
			default: running = 1'b0;
		endcase

		if (cmd) begin
			ramp_d         = '0;
			phase_d        = '0;
			last_d         = '0;
			fade_started_d = 1'b0;
			falling_d      = 1'b0;
			pick_d         = 1'b1;
			colour_d       = '0;
			case (cfg.anim_select)
				SEL_WHEEL, SEL_FADE:         delay_d = cfg.hold_delay_ms;
				SEL_BREATHE7, SEL_BREATHE3:  delay_d = cfg.step_delay_ms;
				default:                     delay_d = '0;
			endcase
			step.emit = 1'b1;
			step.clr  = 1'b1;
		end else if (running && elapsed) begin
			last_d    = now_ms;
			step.emit = 1'b1;
			case (cfg.anim_select)
				SEL_WHEEL: begin
					if (phase_q == 3'd0) begin
						step.wr[0]  = 1'b1;
						step.lvl[0] = mx;
						ramp_d      = '0;
						phase_d     = 3'd1;
						delay_d     = cfg.hold_delay_ms;
					end else if (phase_q != 3'd7) begin
						delay_d = cfg.step_delay_ms;
						case (phase_q)
							3'd1: begin step.wr[1] = 1'b1;  step.lvl[1] = up_lvl; end
							3'd2: begin step.wr[0] = dn_ok; step.lvl[0] = dn_lvl; end
							3'd3: begin step.wr[2] = 1'b1;  step.lvl[2] = up_lvl; end
							3'd4: begin step.wr[1] = dn_ok; step.lvl[1] = dn_lvl; end
							3'd5: begin step.wr[0] = 1'b1;  step.lvl[0] = up_lvl; end
							default: begin step.wr[2] = dn_ok; step.lvl[2] = dn_lvl; end
						endcase
						ramp_d = wrap ? 9'd0 : inc[8:0];
						if (wrap) begin
							if (phase_q == 3'd6) begin
								phase_d = 3'd0;
							end else begin
								phase_d = phase_q + 3'd1;
								delay_d = cfg.hold_delay_ms;
							end
						end
					end
				end
				SEL_FADE: begin
					if (phase_q <= 3'd2) begin
						delay_d = cfg.step_delay_ms;
						case (phase_q)
							3'd0: begin
								step.wr  = {1'b1, dn_ok, 1'b1};
								step.lvl = {mx, dn_lvl, up_lvl};
								if (!fade_started_q) begin
									fade_started_d = 1'b1;
									delay_d        = cfg.hold_delay_ms;
								end
							end
							3'd1: begin
								step.wr  = {dn_ok, 1'b1, 1'b1};
								step.lvl = {dn_lvl, up_lvl, mx};
							end
							default: begin
								step.wr  = {1'b1, 1'b1, dn_ok};
								step.lvl = {up_lvl, mx, dn_lvl};
							end
						endcase
						ramp_d = wrap ? 9'd0 : inc[8:0];
						if (wrap) begin
							phase_d = (phase_q == 3'd2) ? 3'd0 : phase_q + 3'd1;
							delay_d = cfg.hold_delay_ms;
						end
					end
				end
				default: begin
					// breathe through colour numbers 1..7 or 1..3
					delay_d = cfg.step_delay_ms;
					lim     = (cfg.anim_select == SEL_BREATHE7) ? 4'd7 : 4'd3;
					c_next  = {1'b0, colour_q} + 4'd1;
					if (pick_q) begin
						c      = (c_next > lim) ? 3'd1 : c_next[2:0];
						pick_d = 1'b0;
					end
					colour_d = c;
					step.wr  = '1;
					step.lvl[0] = (c inside {3'd1, 3'd4, 3'd6, 3'd7}) ? up_lvl : 8'd0;
					step.lvl[1] = (c inside {3'd2, 3'd4, 3'd5, 3'd7}) ? up_lvl : 8'd0;
					step.lvl[2] = (c inside {3'd3, 3'd5, 3'd6, 3'd7}) ? up_lvl : 8'd0;
					ns = falling_q ? $signed({2'b00, ramp_q}) - 11'sd1
					               : $signed({2'b00, ramp_q}) + 11'sd1;
					if (ns > $signed({3'b000, BREATHE_TOP})) begin
						ramp_d    = {1'b0, BREATHE_TOP};
						falling_d = !falling_q;
						delay_d   = cfg.hold_delay_ms;
					end else if (ns < 11'sd0) begin
						ramp_d    = '0;
						falling_d = !falling_q;
						pick_d    = 1'b1;
					end else begin
						ramp_d = ns[8:0];
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q         <= '0;
			phase_q        <= '0;
			delay_q        <= '0;
			last_q         <= '0;
			fade_started_q <= 1'b0;
			falling_q      <= 1'b0;
			pick_q         <= 1'b1;
			colour_q       <= '0;
		end else if (accept) begin
			ramp_q         <= ramp_d;
			phase_q        <= phase_d;
			delay_q        <= delay_d;
			last_q         <= last_d;
			fade_started_q <= fade_started_d;
			falling_q      <= falling_d;
			pick_q         <= pick_d;
			colour_q       <= colour_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/rgb_led_animation_sequencer_unit.sv
// RGB LED animation sequencer, top level: config registers, step pipeline,
// gamma ROM and duty output register. Depends on rgbl_pkg, rgbl_ifs, rgbl_anim.
//
// Usage:
//  item   : valid/ready beats of {cmd, now_ms}. cmd 0 is a time update, cmd 1
//           restarts the animation and returns black.
//  result : one beat of {red_duty, green_duty, blue_duty} per restart and per
//           time update reaching the current delay while running; others none.
//  cfg    : register writes {index, data}, always ready; write only when idle.
// Throughput is one item per cycle unless the pipeline is backed up. The
// animation state advances in the cycle an item is accepted; the result
// passes the step register, registered gamma ROM read and duty output register.
// Each stage holds while the next is full, so a stalled receiver backs the
// pipeline up and item.ready drops only once all three stages are occupied.
// Reset clears duties to black, animation off, delays 10/500 ms, max level 255,
// gamma off; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none
module rgb_led_animation_sequencer_unit
	import rgbl_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	rgbl_item_if.sink     item,
	rgbl_result_if.source result,
	rgbl_cfg_if.sink      cfg
);

	cfg_t  cfg_q;
	step_t step;
	step_t step_s1;
	step_t step_s2;
	logic  v_s1;
	logic  v_s2;
	logic  out_v_q;
	logic [NUM_CH-1:0][7:0] gam_s2;
	logic [NUM_CH-1:0][7:0] duty_q;

	logic rdy_out;
	logic rdy_s2;
	logic rdy_s1;
	logic adv_s1;
	logic adv_s2;
	logic accept;

	assign rdy_out = !out_v_q || result.ready;
	assign adv_s2  = v_s2 && rdy_out;
	assign rdy_s2  = !v_s2 || rdy_out;
	assign adv_s1  = v_s1 && rdy_s2;
	assign rdy_s1  = !v_s1 || rdy_s2;
	assign accept  = item.valid && rdy_s1;

	assign item.ready = rdy_s1;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.anim_select   <= SEL_OFF;
			cfg_q.step_delay_ms <= 16'd10;
			cfg_q.hold_delay_ms <= 16'd500;
			cfg_q.max_level     <= 8'd255;
			cfg_q.gamma_enable  <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ANIM_SELECT: cfg_q.anim_select   <= cfg.data[2:0];
				REG_STEP_DELAY:  cfg_q.step_delay_ms <= cfg.data;
				REG_HOLD_DELAY:  cfg_q.hold_delay_ms <= cfg.data;
				REG_MAX_LEVEL:   cfg_q.max_level     <= cfg.data[7:0];
				REG_GAMMA_EN:    cfg_q.gamma_enable  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	rgbl_anim u_anim (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.accept (accept),
		.cmd    (item.cmd),
		.now_ms (item.now_ms),
		.step   (step)
	);

	// stage valids and the duty state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
			duty_q  <= '0;
		end else begin
			if (rdy_s1) v_s1 <= accept && step.emit;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_out) out_v_q <= v_s2;
			if (adv_s2) begin
				for (int ch = 0; ch < NUM_CH; ch++) begin
					if (step_s2.clr)
						duty_q[ch] <= 8'd0;
					else if (step_s2.wr[ch])
						duty_q[ch] <= step_s2.gamma_en ? gam_s2[ch] : step_s2.lvl[ch];
				end
			end
		end
	end

	// payload registers and the registered gamma ROM read
	always_ff @(posedge clk) begin
		if (accept) step_s1 <= step;
		if (adv_s1) begin
			step_s2 <= step_s1;
			for (int ch = 0; ch < NUM_CH; ch++)
				gam_s2[ch] <= GAMMA_ROM[step_s1.lvl[ch]];
		end
	end

	assign result.valid      = out_v_q;
	assign result.red_duty   = duty_q[0];
	assign result.green_duty = duty_q[1];
	assign result.blue_duty  = duty_q[2];

endmodule
`default_nettype wire
